### rtl/session_table_idle_timeout_core_assert.svh
// Assertion shorthands for the session table checker.
// Sampled on aclk, switched off while aresetn is low.
`ifndef SESSION_TABLE_IDLE_TIMEOUT_CORE_ASSERT_SVH
`define SESSION_TABLE_IDLE_TIMEOUT_CORE_ASSERT_SVH

`define STIT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

`define STIT_ASSERT_IMPL(lbl, ante, cons, msg) \
    `STIT_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

### rtl/stit_pkg.sv
package stit_pkg;

    localparam int ID_RND_W   = 64;
    localparam int ID_STAMP_W = 16;
    localparam int TIME_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int LIVE_W     = 4;
    localparam int ACTION_W   = 2;

    localparam logic [TIME_W-1:0]     TIMEOUT_RESET  = 32'd300000;
    localparam logic [TIME_W-1:0]     INTERVAL_RESET = 32'd60000;
    localparam logic [ID_STAMP_W-1:0] STAMP_MASK     = 16'hFFFF;

    // configuration register indexes
    localparam logic REG_TIMEOUT  = 1'b0;
    localparam logic REG_INTERVAL = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CREATE,
        ACT_VALIDATE,
        ACT_REVOKE,
        ACT_TICK
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_FULL,
        ST_NOT_FOUND,
        ST_REVOKED,
        ST_EXPIRED
    } status_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_CREATE,
        CMD_VALIDATE,
        CMD_REVOKE,
        CMD_SHIFT
    } cmd_op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_COMPACT
    } state_t;

    // broadcast to every cell
    typedef struct packed {
        cmd_op_t                 op;
        logic [ID_RND_W-1:0]     id_random;
        logic [ID_STAMP_W-1:0]   id_stamp;
        logic [TIME_W-1:0]       clock_ms;
        logic [TIME_W-1:0]       timeout_ms;
    } cell_cmd_t;

    // contents of one slot, handed down during compaction
    typedef struct packed {
        logic                    occupied;
        logic                    valid;
        logic [ID_RND_W-1:0]     id_random;
        logic [ID_STAMP_W-1:0]   id_stamp;
        logic [TIME_W-1:0]       last_used;
    } slot_t;

    // rippled from the oldest cell toward the newest
    typedef struct packed {
        logic prev_occupied;
        logic found;
        logic dead;
        logic sel_valid;
        logic sel_expired;
    } chain_t;

endpackage

### rtl/stit_cell.sv
module stit_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  stit_pkg::cell_cmd_t cmd,
    input  stit_pkg::chain_t   chain_in,
    output stit_pkg::chain_t   chain_out,
    input  stit_pkg::slot_t    upper,
    output stit_pkg::slot_t    slot
);
    import stit_pkg::*;

    logic                  occ_reg, occ_next;
    logic                  valid_reg, valid_next;
    logic [ID_RND_W-1:0]   rnd_reg, rnd_next;
    logic [ID_STAMP_W-1:0] stamp_reg, stamp_next;
    logic [TIME_W-1:0]     last_reg, last_next;

    logic match;
    logic first;
    logic expired;
    logic dead;
    logic [TIME_W-1:0] idle_ms;

    assign idle_ms = cmd.clock_ms - last_reg;
    assign expired = idle_ms > cmd.timeout_ms;
    assign match   = occ_reg && (rnd_reg == cmd.id_random) && (stamp_reg == cmd.id_stamp);
    assign first   = match && !chain_in.found;
    assign dead    = occ_reg && (!valid_reg || expired);

    always_comb begin
        chain_out.prev_occupied = occ_reg;
        chain_out.found         = chain_in.found || match;
        chain_out.dead          = chain_in.dead || dead;
        chain_out.sel_valid     = first ? valid_reg : chain_in.sel_valid;
        chain_out.sel_expired   = first ? expired : chain_in.sel_expired;
    end

    assign slot = '{occupied: occ_reg, valid: valid_reg, id_random: rnd_reg,
                    id_stamp: stamp_reg, last_used: last_reg};

    always_comb begin
        occ_next   = occ_reg;
        valid_next = valid_reg;
        rnd_next   = rnd_reg;
        stamp_next = stamp_reg;
        last_next  = last_reg;
        unique case (cmd.op)
            CMD_CREATE: begin
                // table is packed: the first free slot sits right after the last used one
                if (!occ_reg && chain_in.prev_occupied) begin
                    occ_next   = 1'b1;
                    valid_next = 1'b1;
                    rnd_next   = cmd.id_random;
                    stamp_next = cmd.clock_ms[ID_STAMP_W-1:0] & STAMP_MASK;
                    last_next  = cmd.clock_ms;
                end
            end
            CMD_VALIDATE: begin
                if (first && valid_reg) begin
                    if (expired) begin
                        valid_next = 1'b0;
                    end else begin
                        last_next = cmd.clock_ms;
                    end
                end
            end
            CMD_REVOKE: begin
                if (first) begin
                    valid_next = 1'b0;
                end
            end
            CMD_SHIFT: begin
                // drop the oldest dead entry; everything above moves down one slot
                if (dead || chain_in.dead) begin
                    occ_next   = upper.occupied;
                    valid_next = upper.valid;
                    rnd_next   = upper.id_random;
                    stamp_next = upper.id_stamp;
                    last_next  = upper.last_used;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            occ_reg   <= occ_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rnd_reg   <= rnd_next;
        stamp_reg <= stamp_next;
        last_reg  <= last_next;
    end

endmodule

### rtl/stit_ctrl.sv
module stit_ctrl #(
    parameter int MAX_SESSIONS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [stit_pkg::ACTION_W-1:0]       s_action,
    input  logic [stit_pkg::ID_RND_W-1:0]       s_id_random,
    input  logic [stit_pkg::ID_STAMP_W-1:0]     s_id_stamp,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [stit_pkg::STATUS_W-1:0]       m_status,
    output logic [stit_pkg::ID_RND_W-1:0]       m_out_id_random,
    output logic [stit_pkg::ID_STAMP_W-1:0]     m_out_id_stamp,
    output logic [stit_pkg::LIVE_W-1:0]         m_live_count,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [stit_pkg::TIME_W-1:0]         cfg_wdata,
    output stit_pkg::cell_cmd_t                 cmd,
    input  stit_pkg::chain_t                    chain_end
);
    import stit_pkg::*;

    localparam int CNT_W = $clog2(MAX_SESSIONS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SESSIONS);

    state_t                state_reg, state_next;
    action_t               act_reg;
    logic [ID_RND_W-1:0]   rnd_reg;
    logic [ID_STAMP_W-1:0] stamp_reg;
    logic [TIME_W-1:0]     clock_reg;
    logic [TIME_W-1:0]     last_cleanup_reg;
    logic [TIME_W-1:0]     timeout_reg;
    logic [TIME_W-1:0]     interval_reg;
    logic [CNT_W-1:0]      count_reg, count_next;

    logic                  m_valid_reg;
    status_t               m_status_reg;
    logic [ID_RND_W-1:0]   m_rnd_reg;
    logic [ID_STAMP_W-1:0] m_stamp_reg;
    logic [LIVE_W-1:0]     m_live_reg;

    logic                  out_free;
    logic                  full;
    logic                  is_tick;
    logic                  cleanup_due;
    logic                  exec_go;
    logic                  result_we;
    logic [TIME_W-1:0]     clock_inc;
    logic [TIME_W-1:0]     since_cleanup;
    status_t               status_res;
    logic [ID_RND_W-1:0]   rnd_res;
    logic [ID_STAMP_W-1:0] stamp_res;
    logic [CNT_W+LIVE_W-1:0] live_wide;

    assign out_free      = !m_valid_reg || m_ready;
    assign full          = count_reg == CNT_MAX;
    assign is_tick       = act_reg == ACT_TICK;
    assign clock_inc     = clock_reg + 1'b1;
    assign since_cleanup = clock_inc - last_cleanup_reg;
    assign cleanup_due   = since_cleanup >= interval_reg;
    assign exec_go       = (state_reg == S_EXEC) && out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next = (is_tick && cleanup_due) ? S_COMPACT : S_IDLE;
                end
            end
            S_COMPACT: begin
                if (!chain_end.dead && out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs to the handshake and the cell row
    always_comb begin
        s_ready    = 1'b0;
        cmd.op     = CMD_NONE;
        result_we  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_EXEC: begin
                if (out_free) begin
                    result_we = !(is_tick && cleanup_due);
                    unique case (act_reg)
                        ACT_CREATE:   cmd.op = full ? CMD_NONE : CMD_CREATE;
                        ACT_VALIDATE: cmd.op = CMD_VALIDATE;
                        ACT_REVOKE:   cmd.op = CMD_REVOKE;
                        default:      cmd.op = CMD_NONE;
                    endcase
                end
            end
            S_COMPACT: begin
                cmd.op    = CMD_SHIFT;
                result_we = !chain_end.dead && out_free;
            end
            default: begin
            end
        endcase
        cmd.id_random  = rnd_reg;
        cmd.id_stamp   = stamp_reg;
        cmd.clock_ms   = clock_reg;
        cmd.timeout_ms = timeout_reg;
    end

    always_comb begin
        status_res = ST_OK;
        rnd_res    = '0;
        stamp_res  = '0;
        count_next = count_reg;
        if (exec_go) begin
            case (act_reg)
                ACT_CREATE: begin
                    if (full) begin
                        status_res = ST_FULL;
                    end else begin
                        rnd_res    = rnd_reg;
                        stamp_res  = clock_reg[ID_STAMP_W-1:0] & STAMP_MASK;
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_VALIDATE: begin
                    if (!chain_end.found) begin
                        status_res = ST_NOT_FOUND;
                    end else if (!chain_end.sel_valid) begin
                        status_res = ST_REVOKED;
                    end else if (chain_end.sel_expired) begin
                        status_res = ST_EXPIRED;
                    end
                end
                ACT_REVOKE: begin
                    if (!chain_end.found) begin
                        status_res = ST_NOT_FOUND;
                    end
                end
                default: begin
                end
            endcase
        end else if (state_reg == S_COMPACT && chain_end.dead) begin
            count_next = count_reg - 1'b1;
        end
    end

    // the port keeps the low bits of the count
    assign live_wide = {{LIVE_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            clock_reg        <= '0;
            last_cleanup_reg <= '0;
            timeout_reg      <= TIMEOUT_RESET;
            interval_reg     <= INTERVAL_RESET;
            count_reg        <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_we) begin
                if (cfg_index == REG_TIMEOUT) begin
                    timeout_reg <= cfg_wdata;
                end else if (cfg_index == REG_INTERVAL) begin
                    interval_reg <= cfg_wdata;
                end
            end
            if (exec_go && is_tick) begin
                clock_reg <= clock_inc;
                if (cleanup_due) begin
                    last_cleanup_reg <= clock_inc;
                end
            end
            if (result_we) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            act_reg   <= action_t'(s_action);
            rnd_reg   <= s_id_random;
            stamp_reg <= s_id_stamp;
        end
        if (result_we) begin
            m_status_reg <= status_res;
            m_rnd_reg    <= rnd_res;
            m_stamp_reg  <= stamp_res;
            m_live_reg   <= live_wide[LIVE_W-1:0];
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_out_id_random = m_rnd_reg;
    assign m_out_id_stamp  = m_stamp_reg;
    assign m_live_count    = m_live_reg;

endmodule

### rtl/session_table_idle_timeout_core.sv
// The input transfer registers the request; the EXEC state makes one pass over
//   the cell row and registers the result when the output is free; a tick
//   triggering cleanup goes to COMPACT, dropping one dead entry per cycle and
//   registering the result when none is left. One item is served at a time.
// Reset (aresetn low, synchronous): slots empty, clock and cleanup mark zero,
//   registers back to 300000 / 60000 ms, output empty.
module session_table_idle_timeout_core #(
    parameter int MAX_SESSIONS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [stit_pkg::ACTION_W-1:0]   s_action,
    input  logic [stit_pkg::ID_RND_W-1:0]   s_id_random,
    input  logic [stit_pkg::ID_STAMP_W-1:0] s_id_stamp,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [stit_pkg::STATUS_W-1:0]   m_status,
    output logic [stit_pkg::ID_RND_W-1:0]   m_out_id_random,
    output logic [stit_pkg::ID_STAMP_W-1:0] m_out_id_stamp,
    output logic [stit_pkg::LIVE_W-1:0]     m_live_count,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [stit_pkg::TIME_W-1:0]     cfg_wdata
);
    import stit_pkg::*;

    cell_cmd_t cmd;
    chain_t    chain [MAX_SESSIONS+1];
    slot_t     slots [MAX_SESSIONS+1];

    // oldest end: "previous slot used" is true so an empty table fills slot 0
    assign chain[0] = '{prev_occupied: 1'b1, found: 1'b0, dead: 1'b0,
                        sel_valid: 1'b0, sel_expired: 1'b0};
    assign slots[MAX_SESSIONS] = '0;

    for (genvar g = 0; g < MAX_SESSIONS; g++) begin : g_cell
        stit_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .chain_in  (chain[g]),
            .chain_out (chain[g+1]),
            .upper     (slots[g+1]),
            .slot      (slots[g])
        );
    end

    stit_ctrl #(
        .MAX_SESSIONS (MAX_SESSIONS)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_id_random     (s_id_random),
        .s_id_stamp      (s_id_stamp),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_out_id_random (m_out_id_random),
        .m_out_id_stamp  (m_out_id_stamp),
        .m_live_count    (m_live_count),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .cmd             (cmd),
        .chain_end       (chain[MAX_SESSIONS])
    );

endmodule

### rtl/stit_checker.sv
`include "session_table_idle_timeout_core_assert.svh"

module stit_checker #(
    parameter int MAX_SESSIONS = 8
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [stit_pkg::STATUS_W-1:0]   m_status,
    input logic [stit_pkg::ID_RND_W-1:0]   m_out_id_random,
    input logic [stit_pkg::ID_STAMP_W-1:0] m_out_id_stamp,
    input logic [stit_pkg::LIVE_W-1:0]     m_live_count
);
    import stit_pkg::*;

    localparam logic [LIVE_W-1:0] MAX_LIVE = LIVE_W'(MAX_SESSIONS);

    // a stalled result holds
    `STIT_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_live_count), "result changed while stalled")

    // one item in flight: no back-to-back input transfers
    `STIT_ASSERT_IMPL(a_one_item, s_valid && s_ready, ##1 !s_ready, "input taken twice in a row")

    // only a successful create carries an id
    `STIT_ASSERT_IMPL(a_id_zero, m_valid && (m_status != ST_OK), (m_out_id_random == '0) && (m_out_id_stamp == '0), "id present on non-create result")

    // table full is reported only with every slot in use
    `STIT_ASSERT_IMPL(a_full_count, m_valid && (m_status == ST_FULL), m_live_count == MAX_LIVE, "table full with free slots")

    `STIT_ASSERT_IMPL(a_live_range, m_valid, (MAX_SESSIONS > 15) || (m_live_count <= MAX_LIVE), "live count above table size")

endmodule

bind session_table_idle_timeout_core stit_checker #(
    .MAX_SESSIONS (MAX_SESSIONS)
) u_stit_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_out_id_random (m_out_id_random),
    .m_out_id_stamp  (m_out_id_stamp),
    .m_live_count    (m_live_count)
);
